### hdl/mrq_pkg.sv
package mrq_pkg;

	localparam int SLOT_COUNT = 8;
	localparam int SLOT_BYTES = 32;

	localparam int IDX_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int LEN_W  = $clog2(SLOT_BYTES);
	localparam int ADDR_W = $clog2(SLOT_COUNT * SLOT_BYTES);

	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

	localparam logic [7:0] LF_BYTE  = 8'd10;
	localparam logic [7:0] CR_BYTE  = 8'd13;
	localparam logic [7:0] NUL_BYTE = 8'd0;

	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_CLOSE,
		CMD_DRAIN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LF,
		ST_CR
	} back_state_t;

	function automatic idx_t next_idx(input idx_t i);
		return (i == idx_t'(SLOT_COUNT - 1)) ? '0 : idx_t'(i + idx_t'(1));
	endfunction

	function automatic addr_t slot_addr(input idx_t slot, input len_t pos);
		return addr_t'(slot) * addr_t'(SLOT_BYTES) + addr_t'(pos);
	endfunction

endpackage

### hdl/message_ring_queue_drain.sv
// channel | direction | handshake           | payload
// cmd     | into      | cmd_valid/cmd_stall | mrq_pkg::in_item_t (action, data_byte, end_of_message)
// tx      | out of    | tx_valid/tx_stall   | mrq_pkg::out_item_t (out_byte, last_of_run)
//
// A push is executed from the idle state once it reaches the head of the command queue.
// A drain latches the slot, then reads each byte through the registered slot memory read
// (stopping early at a NUL byte), then sends line feed and carriage return.
// Reset clears pointers, counts and valids; slot memory and lengths are not cleared.
// A stalled tx holds the output register; during a drain the command queue then fills and cmd_stall rises.
module message_ring_queue_drain (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  mrq_pkg::in_item_t   cmd,
	output logic                tx_valid,
	input  logic                tx_stall,
	output mrq_pkg::out_item_t  tx
);

	mrq_pkg::cmd_req_t req;
	logic              req_full;
	logic              head_valid;
	mrq_pkg::cmd_t     head_cmd;
	logic              pop;

	// front: register and classify each item
	mrq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.req       (req),
		.req_full  (req_full)
	);

	// queue: decouple the front from the executor
	mrq_cmd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.full       (req_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	// back: write slots, drain messages, drive tx
	mrq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.tx_valid   (tx_valid),
		.tx_stall   (tx_stall),
		.tx         (tx)
	);

endmodule

### hdl/mrq_front.sv
module mrq_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  mrq_pkg::in_item_t   cmd,
	output mrq_pkg::cmd_req_t   req,
	input  logic                req_full
);

	logic          valid_s1;
	mrq_pkg::cmd_t cmd_s1;
	logic          accept;

	assign cmd_stall = valid_s1 && req_full;
	assign accept    = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && req_full);
		end
	end

	// classify at entry
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.data <= cmd.data_byte;
			if (cmd.action == mrq_pkg::ACT_DRAIN) begin
				cmd_s1.kind <= mrq_pkg::CMD_DRAIN;
			end else if (cmd.end_of_message) begin
				cmd_s1.kind <= mrq_pkg::CMD_CLOSE;
			end else begin
				cmd_s1.kind <= mrq_pkg::CMD_BYTE;
			end
		end
	end

	assign req.valid = valid_s1;
	assign req.cmd   = cmd_s1;

endmodule

### hdl/mrq_cmd_fifo.sv
module mrq_cmd_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  mrq_pkg::cmd_req_t  req,
	output logic               full,
	output logic               head_valid,
	output mrq_pkg::cmd_t      head_cmd,
	input  logic               pop
);

	mrq_pkg::cmd_t                  entry_q [mrq_pkg::CMDQ_DEPTH];
	logic [mrq_pkg::CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [mrq_pkg::CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [mrq_pkg::CMDQ_CNT_W-1:0] count_q;
	logic                           push;
	logic                           do_pop;

	assign full       = (count_q == mrq_pkg::CMDQ_CNT_W'(mrq_pkg::CMDQ_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign push       = req.valid && !full;
	assign do_pop     = pop && head_valid;

	function automatic logic [mrq_pkg::CMDQ_PTR_W-1:0] bump(
		input logic [mrq_pkg::CMDQ_PTR_W-1:0] p);
		return (p == mrq_pkg::CMDQ_PTR_W'(mrq_pkg::CMDQ_DEPTH - 1)) ? '0 :
			mrq_pkg::CMDQ_PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= req.cmd;
		end
	end

endmodule

### hdl/mrq_back.sv
module mrq_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  mrq_pkg::cmd_t       head_cmd,
	output logic                pop,
	output logic                tx_valid,
	input  logic                tx_stall,
	output mrq_pkg::out_item_t  tx
);

	mrq_pkg::back_state_t state_q, state_d;
	mrq_pkg::idx_t        head_q, head_d;
	mrq_pkg::idx_t        tail_q, tail_d;
	mrq_pkg::cnt_t        count_q, count_d;
	mrq_pkg::len_t        fill_q, fill_d;
	mrq_pkg::len_t        pos_q, pos_d;
	mrq_pkg::len_t        len_q, len_d;
	logic                 rd_pend_s1, rd_pend_d;
	logic [7:0]           rdata_s1;

	logic [7:0]           mem [mrq_pkg::SLOT_COUNT * mrq_pkg::SLOT_BYTES];
	mrq_pkg::len_t        slot_len_q [mrq_pkg::SLOT_COUNT];

	logic                 mem_we, mem_re, len_we;
	mrq_pkg::len_t        len_wdata;
	mrq_pkg::len_t        fill_after;
	logic                 out_free, consume, slot_open;
	logic                 load_out;
	mrq_pkg::out_item_t   out_d;
	logic                 out_valid_q;
	mrq_pkg::out_item_t   out_q;

	assign out_free = !out_valid_q || !tx_stall;
	assign consume  = rd_pend_s1 && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrq_pkg::ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			fill_q      <= '0;
			pos_q       <= '0;
			len_q       <= '0;
			rd_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			count_q    <= count_d;
			fill_q     <= fill_d;
			pos_q      <= pos_d;
			len_q      <= len_d;
			rd_pend_s1 <= rd_pend_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!tx_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mrq_pkg::slot_addr(head_q, fill_q)] <= head_cmd.data;
		end
		if (mem_re) begin
			rdata_s1 <= mem[mrq_pkg::slot_addr(tail_q, pos_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (len_we) begin
			slot_len_q[head_q] <= len_wdata;
		end
	end

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		fill_d     = fill_q;
		pos_d      = pos_q;
		len_d      = len_q;
		rd_pend_d  = rd_pend_s1;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		len_we     = 1'b0;
		len_wdata  = '0;
		load_out   = 1'b0;
		out_d      = '0;
		pop        = 1'b0;
		slot_open  = (fill_q != mrq_pkg::LEN_W'(mrq_pkg::SLOT_BYTES - 1));
		fill_after = slot_open ? mrq_pkg::LEN_W'(fill_q + 1'b1) : fill_q;

		case (state_q)
			mrq_pkg::ST_IDLE: begin
				if (head_valid) begin
					pop = 1'b1;
					case (head_cmd.kind)
						mrq_pkg::CMD_BYTE, mrq_pkg::CMD_CLOSE: begin
							// drop bytes past the slot
							mem_we = slot_open;
							fill_d = fill_after;
							if (head_cmd.kind == mrq_pkg::CMD_CLOSE) begin
								len_we    = 1'b1;
								len_wdata = fill_after;
								fill_d    = '0;
								head_d    = mrq_pkg::next_idx(head_q);
								if (count_q != mrq_pkg::CNT_W'(mrq_pkg::SLOT_COUNT)) begin
									count_d = count_q + 1'b1;
								end else begin
									tail_d = mrq_pkg::next_idx(tail_q);
								end
							end
						end
						mrq_pkg::CMD_DRAIN: begin
							if (count_q != '0) begin
								len_d   = slot_len_q[tail_q];
								pos_d   = '0;
								state_d = mrq_pkg::ST_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			mrq_pkg::ST_READ: begin
				if (consume && rdata_s1 == mrq_pkg::NUL_BYTE) begin
					rd_pend_d = 1'b0;
					state_d   = mrq_pkg::ST_LF;
				end else begin
					if (consume) begin
						load_out  = 1'b1;
						out_d     = '{out_byte: rdata_s1, last_of_run: 1'b0};
						rd_pend_d = 1'b0;
					end
					if (!rd_pend_s1 || consume) begin
						if (pos_q != len_q) begin
							mem_re    = 1'b1;
							pos_d     = pos_q + 1'b1;
							rd_pend_d = 1'b1;
						end else begin
							state_d = mrq_pkg::ST_LF;
						end
					end
				end
			end
			mrq_pkg::ST_LF: begin
				if (out_free) begin
					load_out = 1'b1;
					out_d    = '{out_byte: mrq_pkg::LF_BYTE, last_of_run: 1'b0};
					state_d  = mrq_pkg::ST_CR;
				end
			end
			mrq_pkg::ST_CR: begin
				if (out_free) begin
					load_out = 1'b1;
					out_d    = '{out_byte: mrq_pkg::CR_BYTE, last_of_run: 1'b1};
					tail_d   = mrq_pkg::next_idx(tail_q);
					count_d  = count_q - 1'b1;
					state_d  = mrq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mrq_pkg::ST_IDLE;
			end
		endcase
	end

	assign tx_valid = out_valid_q;
	assign tx       = out_q;

endmodule
